// ===== hw/rtl/vaa_pkg.sv =====
// Shared constants, types and helpers for the voice allocator with ADSR envelopes.
package vaa_pkg;

  localparam int NUM_VOICES = 8;
  localparam int VIDX_W     = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;
  localparam int STAMP_W    = 32;
  localparam int LVL_W      = 17;
  localparam int NOTE_W     = 8;
  localparam int VEL_W      = 7;
  localparam int IDX_OUT_W  = 3;

  localparam logic [LVL_W-1:0] ONE_Q16 = 17'h10000;
  localparam logic [VEL_W-1:0] VEL_MAX = 7'd127;

  localparam logic [1:0] OP_NOTE_ON  = 2'd0;
  localparam logic [1:0] OP_NOTE_OFF = 2'd1;
  localparam logic [1:0] OP_ALL_OFF  = 2'd2;
  localparam logic [1:0] OP_TICK     = 2'd3;

  localparam logic [1:0] ST_ATTACK  = 2'd0;
  localparam logic [1:0] ST_DECAY   = 2'd1;
  localparam logic [1:0] ST_SUSTAIN = 2'd2;
  localparam logic [1:0] ST_RELEASE = 2'd3;

  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_LEVEL = 1'b1;

  // Envelope settings as the cells use them: steps already mapped from zero to full scale,
  // sustain already clamped to full scale.
  typedef struct packed {
    logic [LVL_W-1:0] atk;
    logic [LVL_W-1:0] dec;
    logic [LVL_W-1:0] sus;
    logic [LVL_W-1:0] rel;
  } vaa_cfg_t;

  // The command record that walks the chain, plus the running voice search for a note on.
  typedef struct packed {
    logic               valid;
    logic [1:0]         op;
    logic [NOTE_W-1:0]  note;
    logic [VEL_W-1:0]   vel;
    logic               have_free;
    logic               sel_any;
    logic [VIDX_W-1:0]  sel_idx;
    logic [STAMP_W-1:0] sel_stamp;
  } vaa_tok_t;

  // Voice report a cell raises while it handles a tick.
  typedef struct packed {
    logic              valid;
    logic [VIDX_W-1:0] idx;
    logic [NOTE_W-1:0] note;
    logic [VEL_W-1:0]  vel;
    logic [LVL_W-1:0]  level;
    logic [1:0]        stage;
  } vaa_res_t;

  // Broadcast write that starts a voice once the note-on search has finished.
  typedef struct packed {
    logic               en;
    logic [VIDX_W-1:0]  idx;
    logic [NOTE_W-1:0]  note;
    logic [VEL_W-1:0]   vel;
    logic [STAMP_W-1:0] stamp;
  } vaa_wr_t;

  function automatic logic [IDX_OUT_W-1:0] idx_field(input logic [VIDX_W-1:0] i);
    logic [4:0] w;
    w = 5'(i);
    return w[IDX_OUT_W-1:0];
  endfunction

endpackage

// ===== hw/rtl/vaa_cell.sv =====
// One voice cell: voice state, envelope step and one link of the command chain.
module vaa_cell
  import vaa_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              advance,
  input  logic [VIDX_W-1:0] cell_idx,
  input  vaa_cfg_t          cfg,
  input  vaa_wr_t           wr,
  input  vaa_tok_t          tok_in,
  output vaa_tok_t          tok_out,
  output vaa_res_t          res
);

  logic               on;
  logic [NOTE_W-1:0]  key;
  logic [VEL_W-1:0]   vel;
  logic [LVL_W-1:0]   level;
  logic [1:0]         stage;
  logic [STAMP_W-1:0] stamp;

  logic               on_next;
  logic [LVL_W-1:0]   level_next;
  logic [1:0]         stage_next;
  vaa_tok_t           tok_next;

  logic [LVL_W+1:0] sum;
  logic [LVL_W+1:0] dec_diff;
  logic [LVL_W+1:0] rel_diff;

  assign sum      = {2'b00, level} + {2'b00, cfg.atk};
  assign dec_diff = {2'b00, level} - {2'b00, cfg.dec};
  assign rel_diff = {2'b00, level} - {2'b00, cfg.rel};

  always_comb begin
    tok_next   = tok_in;
    on_next    = on;
    level_next = level;
    stage_next = stage;
    res        = '0;
    if (tok_in.valid) begin
      case (tok_in.op)
        OP_NOTE_ON: begin
          // A free voice wins outright; otherwise keep the oldest stamp, first on a tie.
          if (!tok_in.have_free) begin
            if (!on) begin
              tok_next.have_free = 1'b1;
              tok_next.sel_idx   = cell_idx;
            end else if (!tok_in.sel_any || (stamp < tok_in.sel_stamp)) begin
              tok_next.sel_any   = 1'b1;
              tok_next.sel_idx   = cell_idx;
              tok_next.sel_stamp = stamp;
            end
          end
        end
        OP_NOTE_OFF: begin
          if (on && (key == tok_in.note)) begin
            stage_next = ST_RELEASE;
          end
        end
        OP_ALL_OFF: begin
          if (on) begin
            on_next    = 1'b0;
            level_next = '0;
            stage_next = ST_ATTACK;
          end
        end
        default: begin
          if (on) begin
            case (stage)
              ST_ATTACK: begin
                if (sum >= {2'b00, ONE_Q16}) begin
                  level_next = ONE_Q16;
                  stage_next = ST_DECAY;
                end else begin
                  level_next = sum[LVL_W-1:0];
                end
              end
              ST_DECAY: begin
                if ($signed(dec_diff) <= $signed({2'b00, cfg.sus})) begin
                  level_next = cfg.sus;
                  stage_next = ST_SUSTAIN;
                end else begin
                  level_next = dec_diff[LVL_W-1:0];
                end
              end
              ST_SUSTAIN: begin
                level_next = level;
              end
              default: begin
                if ($signed(rel_diff) <= $signed({(LVL_W+2){1'b0}})) begin
                  level_next = '0;
                  on_next    = 1'b0;
                end else begin
                  level_next = rel_diff[LVL_W-1:0];
                end
              end
            endcase
            res.valid = on_next;
            res.idx   = cell_idx;
            res.note  = key;
            res.vel   = vel;
            res.level = level_next;
            res.stage = stage_next;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      on <= 1'b0;
    end else if (wr.en && (wr.idx == cell_idx)) begin
      on <= 1'b1;
    end else if (advance) begin
      on <= on_next;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.en && (wr.idx == cell_idx)) begin
      key   <= wr.note;
      vel   <= wr.vel;
      stamp <= wr.stamp;
      level <= '0;
      stage <= ST_ATTACK;
    end else if (advance) begin
      level <= level_next;
      stage <= stage_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.valid <= 1'b0;
    end else if (advance) begin
      tok_out <= tok_next;
    end
  end

endmodule

// ===== hw/rtl/voice_allocator_adsr.sv =====
// Top level of the polyphonic voice allocator with per-voice ADSR envelopes.
// Each command (note on, note off, all notes off, sample tick) enters a row of NUM_VOICES
// voice cells and walks it one cell per cycle; a new command is accepted only once the
// previous one has left the last cell. The walk pauses while the output register holds
// an untaken transaction. A note on searches the row for the lowest free voice or the
// oldest one, then starts that voice when the record leaves the last cell and emits one
// report. A tick steps every active envelope and emits one transaction per voice still
// sounding, in voice order, with tlast on the final one; note off, all notes off and a
// tick with no sounding voice emit nothing. Configuration writes are taken at any edge
// with cfg_we high and are meant to happen only while the block is idle.
module voice_allocator_adsr
  import vaa_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // Input stream.
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [7:0] note_number, [15:8] velocity_in
  input  logic [1:0]  s_tuser,   // [1:0] op
  // Result stream.
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // [2:0] voice_index, [10:3] voice_note,
                                 // [17:11] voice_velocity, [34:18] envelope_level,
                                 // [36:35] envelope_stage, [37] was_stolen, [39:38] zero
  output logic        m_tuser,   // [0] kind
  output logic        m_tlast,   // last
  // Configuration write port.
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [16:0] cfg_data
);

  localparam logic [1:0] REG_ATTACK  = 2'd0;
  localparam logic [1:0] REG_DECAY   = 2'd1;
  localparam logic [1:0] REG_SUSTAIN = 2'd2;
  localparam logic [1:0] REG_RELEASE = 2'd3;

  // Configuration registers, raw as written.
  logic [LVL_W-1:0] attack_step;
  logic [LVL_W-1:0] decay_step;
  logic [LVL_W-1:0] sustain_level;
  logic [LVL_W-1:0] release_step;

  always_ff @(posedge clk) begin
    if (rst) begin
      attack_step   <= 17'd65536;
      decay_step    <= 17'd65536;
      sustain_level <= 17'd45875;
      release_step  <= 17'd65536;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ATTACK:  attack_step   <= cfg_data;
        REG_DECAY:   decay_step    <= cfg_data;
        REG_SUSTAIN: sustain_level <= cfg_data;
        REG_RELEASE: release_step  <= cfg_data;
        default:     attack_step   <= attack_step;
      endcase
    end
  end

  // A zero step acts as a jump of full scale; sustain above full scale is held at full scale.
  vaa_cfg_t cfg;
  always_comb begin
    cfg.atk = (attack_step == '0) ? ONE_Q16 : attack_step;
    cfg.dec = (decay_step == '0) ? ONE_Q16 : decay_step;
    cfg.rel = (release_step == '0) ? ONE_Q16 : release_step;
    cfg.sus = (sustain_level > ONE_Q16) ? ONE_Q16 : sustain_level;
  end

  // Control.
  logic               busy;
  logic               advance;
  logic               accept;
  logic [STAMP_W-1:0] stamp_counter;

  // Pending tick report: held back one step so the final one can carry tlast.
  logic     hold_valid;
  vaa_res_t hold;

  // Output register.
  logic                 out_valid;
  logic                 out_kind;
  logic [IDX_OUT_W-1:0] out_idx;
  logic [NOTE_W-1:0]    out_note;
  logic [VEL_W-1:0]     out_vel;
  logic [LVL_W-1:0]     out_level;
  logic [1:0]           out_stage;
  logic                 out_stolen;
  logic                 out_last;

  // The chain moves only when the output register can take whatever it produces.
  assign advance  = !out_valid || m_tready;
  assign s_tready = !busy;
  assign accept   = s_tvalid && s_tready;

  vaa_tok_t tok [NUM_VOICES+1];
  vaa_res_t res [NUM_VOICES];
  vaa_res_t cell_res;
  vaa_tok_t tok_exit;
  vaa_wr_t  wr;

  assign tok_exit = tok[NUM_VOICES];

  for (genvar i = 0; i < NUM_VOICES; i++) begin : g_cell
    vaa_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .advance  (advance),
      .cell_idx (VIDX_W'(i)),
      .cfg      (cfg),
      .wr       (wr),
      .tok_in   (tok[i]),
      .tok_out  (tok[i+1]),
      .res      (res[i])
    );
  end

  // Only the cell that holds the command record can raise a report.
  always_comb begin
    cell_res = '0;
    for (int i = 0; i < NUM_VOICES; i++) begin
      if (res[i].valid) begin
        cell_res = res[i];
      end
    end
  end

  // When the note-on record leaves the row, the chosen voice is started.
  always_comb begin
    wr.en    = advance && tok_exit.valid && (tok_exit.op == OP_NOTE_ON);
    wr.idx   = tok_exit.sel_idx;
    wr.note  = tok_exit.note;
    wr.vel   = tok_exit.vel;
    wr.stamp = stamp_counter;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy          <= 1'b0;
      tok[0].valid  <= 1'b0;
      stamp_counter <= '0;
      hold_valid    <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (out_valid && m_tready) begin
        out_valid <= 1'b0;
      end

      if (accept) begin
        busy             <= 1'b1;
        tok[0].valid     <= 1'b1;
        tok[0].op        <= s_tuser;
        tok[0].note      <= s_tdata[7:0];
        tok[0].vel       <= (s_tdata[15:8] > 8'd127) ? VEL_MAX : s_tdata[14:8];
        tok[0].have_free <= 1'b0;
        tok[0].sel_any   <= 1'b0;
        tok[0].sel_idx   <= '0;
        tok[0].sel_stamp <= '0;
      end else if (advance) begin
        tok[0].valid <= 1'b0;
      end

      // A new tick report pushes the held one out as a middle transaction.
      if (advance && cell_res.valid) begin
        hold       <= cell_res;
        hold_valid <= 1'b1;
        if (hold_valid) begin
          out_valid  <= 1'b1;
          out_kind   <= KIND_LEVEL;
          out_idx    <= idx_field(hold.idx);
          out_note   <= hold.note;
          out_vel    <= hold.vel;
          out_level  <= hold.level;
          out_stage  <= hold.stage;
          out_stolen <= 1'b0;
          out_last   <= 1'b0;
        end
      end

      if (advance && tok_exit.valid) begin
        busy <= 1'b0;
        if (tok_exit.op == OP_NOTE_ON) begin
          stamp_counter <= stamp_counter + STAMP_W'(1);
          out_valid     <= 1'b1;
          out_kind      <= KIND_ALLOC;
          out_idx       <= idx_field(tok_exit.sel_idx);
          out_note      <= tok_exit.note;
          out_vel       <= tok_exit.vel;
          out_level     <= '0;
          out_stage     <= ST_ATTACK;
          out_stolen    <= !tok_exit.have_free;
          out_last      <= 1'b1;
        end else if ((tok_exit.op == OP_TICK) && hold_valid) begin
          hold_valid <= 1'b0;
          out_valid  <= 1'b1;
          out_kind   <= KIND_LEVEL;
          out_idx    <= idx_field(hold.idx);
          out_note   <= hold.note;
          out_vel    <= hold.vel;
          out_level  <= hold.level;
          out_stage  <= hold.stage;
          out_stolen <= 1'b0;
          out_last   <= 1'b1;
        end
      end
    end
  end

  assign m_tvalid = out_valid;
  assign m_tuser  = out_kind;
  assign m_tlast  = out_last;
  assign m_tdata  = {2'b00, out_stolen, out_stage, out_level, out_vel, out_note, out_idx};

endmodule

// ===== bench/testbench.sv =====
// Self-checking testbench for the voice allocator with ADSR envelopes.
`timescale 1ns / 1ps

module testbench;
  import vaa_pkg::*;

  // Register indexes on the configuration port.
  localparam logic [1:0] REG_ATTACK  = 2'd0;
  localparam logic [1:0] REG_DECAY   = 2'd1;
  localparam logic [1:0] REG_SUSTAIN = 2'd2;
  localparam logic [1:0] REG_RELEASE = 2'd3;

  // Length of a settling wait, derived from the walk of one command through all voice cells.
  localparam int WALK_CYCLES = 2 * (NUM_VOICES + 2);
  localparam int RANDOM_PHASES = 8;
  localparam int ITEMS_PER_PHASE = 17;

  // One result transaction, unpacked from m_tdata, m_tuser and m_tlast.
  typedef struct packed {
    logic             kind;
    logic [2:0]       idx;
    logic [7:0]       note;
    logic [6:0]       vel;
    logic [LVL_W-1:0] level;
    logic [1:0]       stage;
    logic             stolen;
    logic             last;
  } voice_report_t;

  // One row of the directed table. Rows with a typed report bypass the predictor's output.
  typedef struct packed {
    logic [1:0]    op;
    logic [7:0]    note;
    logic [7:0]    vel;
    logic          typed;
    voice_report_t want;
  } stim_row_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = '0;
  logic [1:0]  s_tuser = OP_TICK;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;
  logic        m_tuser;
  logic        m_tlast;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = REG_ATTACK;
  logic [16:0] cfg_data = '0;

  voice_allocator_adsr i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // Shadow copy of the voice bank and of the envelope registers.
  logic             bank_on    [NUM_VOICES];
  logic [7:0]       bank_key   [NUM_VOICES];
  logic [6:0]       bank_vel   [NUM_VOICES];
  logic [LVL_W-1:0] bank_level [NUM_VOICES];
  logic [1:0]       bank_stage [NUM_VOICES];
  logic [31:0]      bank_stamp [NUM_VOICES];
  logic [31:0]      next_stamp;
  logic [16:0]      env_reg    [4];

  // Reports still owed by the block, oldest first.
  voice_report_t pending_reports[$];

  int gap_pct = 0;
  int stall_pct = 0;
  int mismatches = 0;
  int reports_checked = 0;
  int commands_sent = 0;
  stim_row_t directed_rows[24];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop in case the block hangs; far above the slowest legal run.
  initial begin
    #5_000_000;
    $display("FAILURE");
    $finish;
  end

  // The receiver throttles at random according to the current phase.
  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= stall_pct);
  end

  // A zero step register means an instant jump of full scale.
  function automatic longint step_or_full(logic [16:0] s);
    return (s == 17'd0) ? longint'(ONE_Q16) : longint'(s);
  endfunction

  function automatic voice_report_t make_report(logic kind, int v, logic stolen);
    voice_report_t r;
    r.kind   = kind;
    r.idx    = v[2:0];
    r.note   = bank_key[v];
    r.vel    = bank_vel[v];
    r.level  = bank_level[v];
    r.stage  = bank_stage[v];
    r.stolen = stolen;
    r.last   = 1'b0;
    return r;
  endfunction

  // Applies one command to the shadow bank and queues the reports the block must give for it.
  function automatic void advance_voice_bank(logic [1:0] op, logic [7:0] note, logic [7:0] vel_in);
    int pick;
    logic stolen;
    logic [31:0] oldest;
    longint lv;
    longint sus;
    voice_report_t r;
    voice_report_t tick_reports[$];
    pick = -1;
    stolen = 1'b0;
    case (op)
      OP_NOTE_ON: begin
        for (int v = 0; v < NUM_VOICES; v++) begin
          if (!bank_on[v] && pick < 0) pick = v;
        end
        // No free voice: take the oldest stamp, the lowest index on a tie.
        if (pick < 0) begin
          stolen = 1'b1;
          pick = 0;
          oldest = bank_stamp[0];
          for (int v = 1; v < NUM_VOICES; v++) begin
            if (bank_stamp[v] < oldest) begin
              oldest = bank_stamp[v];
              pick = v;
            end
          end
        end
        bank_on[pick]    = 1'b1;
        bank_key[pick]   = note;
        bank_stamp[pick] = next_stamp;
        next_stamp       = next_stamp + 32'd1;
        bank_vel[pick]   = (vel_in > 8'd127) ? VEL_MAX : vel_in[6:0];
        bank_stage[pick] = ST_ATTACK;
        bank_level[pick] = '0;
        r = make_report(KIND_ALLOC, pick, stolen);
        r.last = 1'b1;
        pending_reports.push_back(r);
      end
      OP_NOTE_OFF: begin
        for (int v = 0; v < NUM_VOICES; v++) begin
          if (bank_on[v] && bank_key[v] == note) bank_stage[v] = ST_RELEASE;
        end
      end
      OP_ALL_OFF: begin
        for (int v = 0; v < NUM_VOICES; v++) begin
          if (bank_on[v]) begin
            bank_on[v]    = 1'b0;
            bank_level[v] = '0;
            bank_stage[v] = ST_ATTACK;
          end
        end
      end
      default: begin
        sus = (env_reg[REG_SUSTAIN] > ONE_Q16) ? longint'(ONE_Q16)
                                               : longint'(env_reg[REG_SUSTAIN]);
        for (int v = 0; v < NUM_VOICES; v++) begin
          if (bank_on[v]) begin
            lv = longint'(bank_level[v]);
            case (bank_stage[v])
              ST_ATTACK: begin
                lv += step_or_full(env_reg[REG_ATTACK]);
                if (lv >= longint'(ONE_Q16)) begin
                  lv = ONE_Q16;
                  bank_stage[v] = ST_DECAY;
                end
              end
              ST_DECAY: begin
                lv -= step_or_full(env_reg[REG_DECAY]);
                if (lv <= sus) begin
                  lv = sus;
                  bank_stage[v] = ST_SUSTAIN;
                end
              end
              ST_SUSTAIN: ;
              default: begin
                lv -= step_or_full(env_reg[REG_RELEASE]);
                if (lv <= 0) begin
                  lv = 0;
                  bank_on[v] = 1'b0;
                end
              end
            endcase
            bank_level[v] = lv[LVL_W-1:0];
            if (bank_on[v]) tick_reports.push_back(make_report(KIND_LEVEL, v, 1'b0));
          end
        end
        if (tick_reports.size() > 0) tick_reports[tick_reports.size()-1].last = 1'b1;
        foreach (tick_reports[k]) pending_reports.push_back(tick_reports[k]);
      end
    endcase
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  // Every result transaction is matched against the oldest outstanding report.
  always @(posedge clk) begin : watch_results
    voice_report_t got;
    voice_report_t want;
    if (!rst && m_tvalid && m_tready) begin
      got.kind   = m_tuser;
      got.idx    = m_tdata[2:0];
      got.note   = m_tdata[10:3];
      got.vel    = m_tdata[17:11];
      got.level  = m_tdata[34:18];
      got.stage  = m_tdata[36:35];
      got.stolen = m_tdata[37];
      got.last   = m_tlast;
      if (pending_reports.size() == 0) begin
        $error("result transaction with no report outstanding: %p", got);
        mismatches++;
      end else begin
        want = pending_reports.pop_front();
        check_field("kind", want.kind, got.kind);
        check_field("voice_index", want.idx, got.idx);
        check_field("voice_note", want.note, got.note);
        check_field("voice_velocity", want.vel, got.vel);
        check_field("envelope_level", want.level, got.level);
        check_field("envelope_stage", want.stage, got.stage);
        check_field("was_stolen", want.stolen, got.stolen);
        check_field("last", want.last, got.last);
        reports_checked++;
      end
    end
  end

  // Offers one command and returns at the edge that accepts it, leaving tvalid high.
  // The caller either presents the next command or lowers tvalid in the same time step.
  task automatic send_command(input logic [1:0] op, input logic [7:0] note,
                              input logic [7:0] vel);
    while ($urandom_range(99) < gap_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {vel, note};
    do @(posedge clk); while (!s_tready);
    commands_sent++;
  endtask

  // Drains every outstanding report, then gives the block time to finish commands
  // that produce no report (note off, all notes off, an empty tick).
  task automatic wait_until_quiet();
    s_tvalid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (WALK_CYCLES) @(posedge clk);
  endtask

  // Writes all four envelope registers on back-to-back edges while the block is idle.
  task automatic load_envelope(input logic [16:0] atk, input logic [16:0] dec,
                               input logic [16:0] sus, input logic [16:0] rel);
    logic [16:0] vals[4];
    vals = '{atk, dec, sus, rel};
    for (int k = 0; k < 4; k++) begin
      cfg_we    <= 1'b1;
      cfg_index <= k[1:0];
      cfg_data  <= vals[k];
      env_reg[k] = vals[k];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  function automatic stim_row_t plain_row(logic [1:0] op, logic [7:0] note, logic [7:0] vel);
    stim_row_t row;
    row = '0;
    row.op = op;
    row.note = note;
    row.vel = vel;
    return row;
  endfunction

  // A note on whose report is known by inspection.
  function automatic stim_row_t alloc_row(logic [7:0] note, logic [7:0] vel, logic [2:0] idx,
                                          logic [6:0] exp_vel, logic stolen);
    stim_row_t row;
    row = plain_row(OP_NOTE_ON, note, vel);
    row.typed = 1'b1;
    row.want = '{kind: KIND_ALLOC, idx: idx, note: note, vel: exp_vel, level: '0,
                 stage: ST_ATTACK, stolen: stolen, last: 1'b1};
    return row;
  endfunction

  initial begin : stimulus
    logic [16:0] set_atk;
    logic [16:0] set_dec;
    logic [16:0] set_sus;
    logic [16:0] set_rel;
    int pick;
    logic [1:0] op;
    logic [7:0] note;

    for (int v = 0; v < NUM_VOICES; v++) begin
      bank_on[v] = 1'b0;
      bank_key[v] = '0;
      bank_vel[v] = '0;
      bank_level[v] = '0;
      bank_stage[v] = ST_ATTACK;
      bank_stamp[v] = '0;
    end
    next_stamp = '0;
    env_reg = '{17'd65536, 17'd65536, 17'd45875, 17'd65536};

    // Directed part, run with the registers at their reset values. Voices fill from the
    // bottom, velocity saturates at 127, a full bank steals the oldest voices in turn, a
    // note off of an unheld note does nothing, and a voice released during attack frees
    // itself on the next tick without a report.
    directed_rows = '{
      alloc_row(8'd0,   8'd255, 3'd0, 7'd127, 1'b0),
      alloc_row(8'd255, 8'd0,   3'd1, 7'd0,   1'b0),
      alloc_row(8'd60,  8'd127, 3'd2, 7'd127, 1'b0),
      alloc_row(8'd61,  8'd128, 3'd3, 7'd127, 1'b0),
      plain_row(OP_TICK, 8'hA5, 8'h5A),
      plain_row(OP_TICK, 8'h00, 8'h00),
      plain_row(OP_NOTE_OFF, 8'd60, 8'd0),
      plain_row(OP_TICK, 8'hFF, 8'hFF),
      alloc_row(8'd62,  8'd64,  3'd2, 7'd64,  1'b0),
      alloc_row(8'd63,  8'd1,   3'd4, 7'd1,   1'b0),
      alloc_row(8'd64,  8'd2,   3'd5, 7'd2,   1'b0),
      alloc_row(8'd65,  8'd3,   3'd6, 7'd3,   1'b0),
      alloc_row(8'd66,  8'd200, 3'd7, 7'd127, 1'b0),
      alloc_row(8'd70,  8'd100, 3'd0, 7'd100, 1'b1),
      alloc_row(8'd71,  8'd126, 3'd1, 7'd126, 1'b1),
      alloc_row(8'd72,  8'd255, 3'd3, 7'd127, 1'b1),
      plain_row(OP_NOTE_OFF, 8'd71, 8'd0),
      plain_row(OP_NOTE_OFF, 8'd200, 8'd0),
      plain_row(OP_TICK, 8'h00, 8'h00),
      plain_row(OP_ALL_OFF, 8'h3C, 8'hC3),
      plain_row(OP_TICK, 8'h00, 8'h00),
      alloc_row(8'd5,   8'd127, 3'd0, 7'd127, 1'b0),
      plain_row(OP_NOTE_OFF, 8'd5, 8'd0),
      plain_row(OP_TICK, 8'h00, 8'h00)
    };

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[k]) begin
      send_command(directed_rows[k].op, directed_rows[k].note, directed_rows[k].vel);
      advance_voice_bank(directed_rows[k].op, directed_rows[k].note, directed_rows[k].vel);
      // A typed row replaces the predicted note-on report with the one written out above.
      if (directed_rows[k].typed) begin
        void'(pending_reports.pop_back());
        pending_reports.push_back(directed_rows[k].want);
      end
    end

    // Random part. Each phase loads a new envelope setting and a new idling pattern:
    // none, sender mostly idle, receiver mostly stalled, then both now and then.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      wait_until_quiet();
      case (p)
        0: begin set_atk = 17'd65536; set_dec = 17'd65536; set_sus = 17'd45875;
                 set_rel = 17'd65536; end
        1: begin set_atk = 17'd1; set_dec = 17'd1; set_sus = 17'd0; set_rel = 17'd1; end
        // Zero steps jump at once; a sustain above full scale is held at full scale.
        2: begin set_atk = 17'd0; set_dec = 17'd0; set_sus = 17'h1FFFF; set_rel = 17'd0; end
        3: begin set_atk = ONE_Q16; set_dec = ONE_Q16; set_sus = ONE_Q16;
                 set_rel = ONE_Q16; end
        7: begin
          set_atk = $urandom_range(0, 131071);
          set_dec = $urandom_range(0, 131071);
          set_sus = $urandom_range(0, 131071);
          set_rel = $urandom_range(0, 131071);
        end
        default: begin
          // Steps large enough that voices pass through every stage within a few ticks.
          set_atk = $urandom_range(4000, 40000);
          set_dec = $urandom_range(2000, 30000);
          set_sus = $urandom_range(0, 65536);
          set_rel = $urandom_range(4000, 40000);
        end
      endcase
      load_envelope(set_atk, set_dec, set_sus, set_rel);
      case (p % 4)
        0: begin gap_pct = 0;  stall_pct = 0;  end
        1: begin gap_pct = 87; stall_pct = 0;  end
        2: begin gap_pct = 0;  stall_pct = 87; end
        default: begin gap_pct = 19; stall_pct = 19; end
      endcase

      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        pick = $urandom_range(99);
        if (pick < 35) op = OP_NOTE_ON;
        else if (pick < 55) op = OP_NOTE_OFF;
        else if (pick < 60) op = OP_ALL_OFF;
        else op = OP_TICK;
        // A small pool of notes makes note offs hit held voices, including duplicates.
        note = ($urandom_range(99) < 75) ? 8'($urandom_range(60, 67)) : 8'($urandom_range(0, 255));
        send_command(op, note, 8'($urandom_range(0, 255)));
        advance_voice_bank(op, note, s_tdata[15:8]);
      end
    end

    wait_until_quiet();
    $display("Sent %0d commands across %0d envelope settings and four idling patterns.",
             commands_sent, RANDOM_PHASES + 1);
    $display("Checked %0d result transactions field by field.", reports_checked);
    if (mismatches == 0 && pending_reports.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/vaa_pkg.sv
hw/rtl/vaa_cell.sv
hw/rtl/voice_allocator_adsr.sv
bench/testbench.sv
